// ===== rtl/core/sem_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the Sobel energy map unit: configuration
// register indexes, field widths, controller states, command and status.
// ----------------------------------------------------------------------------
package sem_pkg;

	localparam int DEF_MAX_WIDTH   = 2048;
	localparam int DEF_MAX_HEIGHT  = 4096;

	localparam int WIDTH_REG_BITS  = 12;
	localparam int HEIGHT_REG_BITS = 13;
	localparam int CFG_DATA_BITS   = 13;
	localparam int CFG_INDEX_BITS  = 1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [WIDTH_REG_BITS-1:0]  RESET_WIDTH  = 12'd640;
	localparam logic [HEIGHT_REG_BITS-1:0] RESET_HEIGHT = 13'd480;

	localparam int PIXEL_BITS   = 8;
	localparam int ENERGY_BITS  = 8;
	localparam int SUM3_BITS    = 10;
	localparam int GRAD_BITS    = 11;
	localparam int SQ_BITS      = 21;
	localparam int ROOT_IN_BITS = 16;
	localparam int ROOT_BITS    = 8;

	localparam logic [ENERGY_BITS-1:0] ENERGY_SAT = 8'd255;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROC,
		ST_GRAD,
		ST_SQR,
		ST_SUM,
		ST_ROOT,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic accept;
		logic shift;
		logic grad;
		logic square;
		logic root_start;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic emit;
		logic root_done;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/sem_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sem_isqrt
// Floor integer square root of a 16-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module sem_isqrt (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic [sem_pkg::ROOT_IN_BITS-1:0]      value,
	output logic      [sem_pkg::ROOT_BITS-1:0]         root,
	output logic                                       done
);
	import sem_pkg::*;

	localparam int REM_BITS = ROOT_BITS + 1;
	localparam int RS_BITS  = ROOT_BITS + 3;
	localparam int CNT_BITS = $clog2(ROOT_BITS + 1);

	logic [ROOT_IN_BITS-1:0] v_q;
	logic [REM_BITS-1:0]     rem_q;
	logic [ROOT_BITS-1:0]    root_q;
	logic [CNT_BITS-1:0]     cnt_q;
	logic                    busy_q;
	logic                    done_q;

	logic [RS_BITS-1:0] rem_sh;
	logic [RS_BITS-1:0] trial;
	logic [RS_BITS-1:0] diff;
	logic               ge;

	always_comb begin
		rem_sh = {rem_q, v_q[ROOT_IN_BITS-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		ge     = rem_sh >= trial;
		diff   = rem_sh - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_BITS'(ROOT_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_BITS'(1);
			if (cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[ROOT_IN_BITS-3:0], 2'b00};
			rem_q  <= ge ? diff[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
			root_q <= {root_q[ROOT_BITS-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule
`default_nettype wire

// ===== rtl/core/sem_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sem_datapath
// Line stores, 3x3 window, position counters, gradient and magnitude
// arithmetic, configuration registers and the result register.
// ----------------------------------------------------------------------------
module sem_datapath #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_write_en,
	input  wire logic [sem_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  wire logic [sem_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	input  wire logic [sem_pkg::PIXEL_BITS-1:0]         pixel,
	input  wire logic                                   flush,
	input  wire sem_pkg::dp_cmd_t                       cmd,
	output sem_pkg::dp_stat_t                           stat,
	input  wire logic                                   out_ready,
	output logic                                        out_valid,
	output logic      [sem_pkg::ENERGY_BITS-1:0]        energy,
	output logic                                        last_of_frame
);
	import sem_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int CW1 = CW + 1;
	localparam int RW  = $clog2(MAX_HEIGHT + 2);

	// configuration
	logic [WIDTH_REG_BITS-1:0]  image_width_q;
	logic [HEIGHT_REG_BITS-1:0] image_height_q;
	logic [CW1-1:0]             eff_w;
	logic [RW-1:0]              eff_h;

	// position counters
	logic [CW-1:0]  in_col_q;
	logic [RW-1:0]  in_row_q;
	logic [CW-1:0]  out_col_q;
	logic [RW-1:0]  out_row_q;
	logic [CW1-1:0] in_col_inc;
	logic [CW1-1:0] out_col_inc;
	logic [RW-1:0]  out_row_inc;
	logic           is_last;

	// line stores and window
	logic [PIXEL_BITS-1:0] upper_mem  [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] middle_mem [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] up_rd_q;
	logic [PIXEL_BITS-1:0] mid_rd_q;
	logic [PIXEL_BITS-1:0] val_q;
	logic [PIXEL_BITS-1:0] win_q [9];

	// arithmetic
	logic [2:0]                   row_ok;
	logic [2:0]                   col_ok;
	logic [PIXEL_BITS-1:0]        px [9];
	logic [SUM3_BITS-1:0]         row_top, row_bot, col_left, col_right;
	logic signed [GRAD_BITS-1:0]  gx_next, gy_next;
	logic signed [GRAD_BITS-1:0]  gx_q, gy_q;
	logic signed [2*GRAD_BITS-1:0] gx_sq, gy_sq;
	logic [SQ_BITS-1:0]           sqx_q, sqy_q;
	logic [SQ_BITS:0]             sq_sum;
	logic                         sat_q;
	logic                         res_last_q;
	logic [ROOT_BITS-1:0]         root;
	logic                         root_done;

	// result register
	logic                   out_valid_q;
	logic [ENERGY_BITS-1:0] energy_q;
	logic                   last_q;

	always_comb begin
		if (image_width_q == '0) begin
			eff_w = CW1'(1);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			eff_w = CW1'(MAX_WIDTH);
		end else begin
			eff_w = CW1'(image_width_q);
		end
		if (image_height_q == '0) begin
			eff_h = RW'(1);
		end else if (32'(image_height_q) > 32'(MAX_HEIGHT)) begin
			eff_h = RW'(MAX_HEIGHT);
		end else begin
			eff_h = RW'(image_height_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= RESET_WIDTH;
			image_height_q <= RESET_HEIGHT;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[WIDTH_REG_BITS-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[HEIGHT_REG_BITS-1:0];
			endcase
		end
	end

	assign in_col_inc  = {1'b0, in_col_q} + CW1'(1);
	assign out_col_inc = {1'b0, out_col_q} + CW1'(1);
	assign out_row_inc = out_row_q + RW'(1);
	assign is_last     = (out_row_q == eff_h - RW'(1)) && (out_col_inc == eff_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_write_en) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			if (cmd.shift) begin
				if (in_col_inc >= eff_w) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RW'(1);
				end else begin
					in_col_q <= in_col_inc[CW-1:0];
				end
			end
			if (cmd.grad) begin
				if (is_last) begin
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else if (out_col_inc >= eff_w) begin
					out_col_q <= '0;
					out_row_q <= out_row_inc;
				end else begin
					out_col_q <= out_col_inc[CW-1:0];
				end
			end
		end
	end

	// line stores: read on transfer, write back in the following cycle
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			up_rd_q  <= upper_mem[in_col_q];
			mid_rd_q <= middle_mem[in_col_q];
		end
		if (cmd.shift) begin
			upper_mem[in_col_q]  <= mid_rd_q;
			middle_mem[in_col_q] <= val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			val_q <= (flush || (in_row_q >= eff_h)) ? '0 : pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.shift) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]   <= win_q[r*3+1];
				win_q[r*3+1] <= win_q[r*3+2];
			end
			win_q[2] <= up_rd_q;
			win_q[5] <= mid_rd_q;
			win_q[8] <= val_q;
		end
	end

	// neighbors outside the image read as zero
	always_comb begin
		row_ok = {(out_row_inc < eff_h), 1'b1, (out_row_q != '0)};
		col_ok = {(out_col_inc < eff_w), 1'b1, (out_col_q != '0)};
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				px[r*3+c] = (row_ok[r] && col_ok[c]) ? win_q[r*3+c] : '0;
			end
		end
		row_top   = SUM3_BITS'(px[0]) + {1'b0, px[1], 1'b0} + SUM3_BITS'(px[2]);
		row_bot   = SUM3_BITS'(px[6]) + {1'b0, px[7], 1'b0} + SUM3_BITS'(px[8]);
		col_left  = SUM3_BITS'(px[0]) + {1'b0, px[3], 1'b0} + SUM3_BITS'(px[6]);
		col_right = SUM3_BITS'(px[2]) + {1'b0, px[5], 1'b0} + SUM3_BITS'(px[8]);
		gx_next   = $signed({1'b0, row_bot}) - $signed({1'b0, row_top});
		gy_next   = $signed({1'b0, col_right}) - $signed({1'b0, col_left});
	end

	assign gx_sq  = gx_q * gx_q;
	assign gy_sq  = gy_q * gy_q;
	assign sq_sum = {1'b0, sqx_q} + {1'b0, sqy_q};

	always_ff @(posedge clk) begin
		if (cmd.grad) begin
			gx_q       <= gx_next;
			gy_q       <= gy_next;
			res_last_q <= is_last;
		end
		if (cmd.square) begin
			sqx_q <= gx_sq[SQ_BITS-1:0];
			sqy_q <= gy_sq[SQ_BITS-1:0];
		end
		if (cmd.root_start) begin
			sat_q <= |sq_sum[SQ_BITS:ROOT_IN_BITS];
		end
	end

	sem_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.root_start),
		.value  (sq_sum[ROOT_IN_BITS-1:0]),
		.root   (root),
		.done   (root_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			energy_q <= sat_q ? ENERGY_SAT : root;
			last_q   <= res_last_q;
		end
	end

	assign stat.emit      = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
	assign stat.root_done = root_done;
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign energy        = energy_q;
	assign last_of_frame = last_q;

`ifndef SYNTH
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before transfer");

	a_in_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, in_col_q} < eff_w)
		else $error("input column past row end");

	a_out_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_row_q < eff_h)
		else $error("output row past frame end");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.grad && is_last && !cfg_write_en) |=> (out_row_q == '0 && in_row_q == '0))
		else $error("frame not restarted after last result");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/sem_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sem_ctrl
// Controller state machine: sequences window update, gradient, squaring,
// square root and result load for one pixel at a time.
// ----------------------------------------------------------------------------
module sem_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output sem_pkg::dp_cmd_t       cmd,
	input  wire sem_pkg::dp_stat_t stat
);
	import sem_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_next = ST_PROC;
				end
			end
			ST_PROC: begin
				cmd.shift  = 1'b1;
				state_next = stat.emit ? ST_GRAD : ST_IDLE;
			end
			ST_GRAD: begin
				cmd.grad   = 1'b1;
				state_next = ST_SQR;
			end
			ST_SQR: begin
				cmd.square = 1'b1;
				state_next = ST_SUM;
			end
			ST_SUM: begin
				cmd.root_start = 1'b1;
				state_next     = ST_ROOT;
			end
			ST_ROOT: begin
				if (stat.root_done) begin
					if (stat.out_free) begin
						cmd.load_out = 1'b1;
						state_next   = ST_IDLE;
					end else begin
						state_next = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/sobel_energy_map_unit.sv =====
// a pixel that gives no result only passes the window shift; one that completes a result
// goes on through gradient, squaring, sum and root states, and waits while the output is full
// no new pixel is accepted before the previous one is through; the square root takes 8 steps
// reset: async, clears counters, window and result valid flag; width 640, height 480
// line stores are not cleared; entries are only used after being written
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_energy_map_unit
// Streaming 3x3 Sobel gradient magnitude over raster-order gray pixels,
// saturated to 8 bits, with flush transfers draining the frame.
// ----------------------------------------------------------------------------
module sobel_energy_map_unit #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write_en,
	input  wire logic [sem_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [sem_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [sem_pkg::PIXEL_BITS-1:0]     pixel,
	input  wire logic                               flush,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic      [sem_pkg::ENERGY_BITS-1:0]    energy,
	output logic                                    last_of_frame
);
	import sem_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	sem_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pixel         (pixel),
		.flush         (flush),
		.cmd           (cmd),
		.stat          (stat),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.energy        (energy),
		.last_of_frame (last_of_frame)
	);

endmodule
`default_nettype wire
